/* rtl/core/dpbp_pkg.sv */
package dpbp_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;

  localparam int PROD_W  = 40;
  localparam int Z_SHIFT = 24 - FRAC_BITS;
  localparam int Z_W     = PROD_W - Z_SHIFT;
  localparam int CMP_W   = (Z_W > 32) ? Z_W : 32;
  localparam int DIFF_W  = 21;
  localparam int MAG_W   = 20;
  localparam int A_W     = 44;
  localparam int AH_W    = A_W - 32;
  localparam int M_W     = AH_W + Z_W + 1;
  localparam int SUM_W   = 66;

  localparam int POSE_ROWS  = 3;
  localparam int POSE_COLS  = 4;
  localparam int POSE_WORDS = POSE_ROWS * POSE_COLS;

  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int Q_CW     = Q_AW + 1;
  localparam int OB_DEPTH = 8;
  localparam int OB_AW    = $clog2(OB_DEPTH);
  localparam int OB_CW    = OB_AW + 1;

  localparam logic [11:0] COORD_MASK = 12'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic signed [31:0] ONE_POSE = 32'sd65536;

  localparam logic [2:0] CFG_INV_FOCAL_X    = 3'd0;
  localparam logic [2:0] CFG_INV_FOCAL_Y    = 3'd1;
  localparam logic [2:0] CFG_CENTER_X       = 3'd2;
  localparam logic [2:0] CFG_CENTER_Y       = 3'd3;
  localparam logic [2:0] CFG_INV_DEPTH_UNIT = 3'd4;
  localparam logic [2:0] CFG_MIN_DEPTH      = 3'd5;
  localparam logic [2:0] CFG_MAX_DEPTH      = 3'd6;

  typedef enum logic {ITEM_PIXEL, ITEM_POSE} item_kind_t;

  typedef struct packed {
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
    logic [19:0] center_x;
    logic [19:0] center_y;
    logic [23:0] inv_depth_unit;
    logic [31:0] min_depth;
    logic [31:0] max_depth;
  } cfg_t;

  typedef struct packed {
    item_kind_t               kind;
    logic [Z_W-1:0]           z;
    logic signed [DIFF_W-1:0] du;
    logic signed [DIFF_W-1:0] dv;
    logic [7:0]               red;
    logic [7:0]               green;
    logic [7:0]               blue;
    logic [3:0]               pose_index;
    logic signed [31:0]       pose_value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } result_t;

endpackage

/* rtl/core/depth_pixel_backprojection_unit.sv */
// Back-projects one RGB-D pixel per clock while in_full is low, through pinhole intrinsics
// and a 3x4 rigid pose, giving world x, y, z in signed Q15.16 with the color. Items are
// taken one per clock while in_full is low; it rises once the item queue fills behind a
// full eight-entry result buffer. A kept pixel passes one front register, the item queue
// and four back stages (focal product, partial products, camera point, pose products)
// into that buffer. Pose loads (op 1) give no result and apply to every pixel pushed after
// them; pixels with zero depth, depth outside the window or a zero focal reciprocal give no
// result. The user must write configuration only while no item is in flight; unenforced.
module depth_pixel_backprojection_unit
  import dpbp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_op,
  input  logic [11:0]        in_column,
  input  logic [11:0]        in_row,
  input  logic [15:0]        in_depth_raw,
  input  logic [7:0]         in_red_in,
  input  logic [7:0]         in_green_in,
  input  logic [7:0]         in_blue_in,
  input  logic [3:0]         in_pose_index,
  input  logic signed [31:0] in_pose_value,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_world_x,
  output logic signed [31:0] out_world_y,
  output logic signed [31:0] out_world_z,
  output logic [7:0]         out_red_out,
  output logic [7:0]         out_green_out,
  output logic [7:0]         out_blue_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t            cfg_r;
  logic            q_push;
  item_t           q_in;
  logic            q_pop;
  item_t           q_out;
  logic            q_empty;
  logic [Q_CW-1:0] q_count;
  result_t         res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_focal_x    <= 24'd32263;
      cfg_r.inv_focal_y    <= 24'd32263;
      cfg_r.center_x       <= 20'd81920;
      cfg_r.center_y       <= 20'd61440;
      cfg_r.inv_depth_unit <= 24'd16777;
      cfg_r.min_depth      <= 32'd19661;
      cfg_r.max_depth      <= 32'd655360;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INV_FOCAL_X:    cfg_r.inv_focal_x    <= cfg_data[23:0];
        CFG_INV_FOCAL_Y:    cfg_r.inv_focal_y    <= cfg_data[23:0];
        CFG_CENTER_X:       cfg_r.center_x       <= cfg_data[19:0];
        CFG_CENTER_Y:       cfg_r.center_y       <= cfg_data[19:0];
        CFG_INV_DEPTH_UNIT: cfg_r.inv_depth_unit <= cfg_data[23:0];
        CFG_MIN_DEPTH:      cfg_r.min_depth      <= cfg_data;
        CFG_MAX_DEPTH:      cfg_r.max_depth      <= cfg_data;
        default: ;
      endcase
    end
  end

  dpbp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_column     (in_column),
    .in_row        (in_row),
    .in_depth_raw  (in_depth_raw),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .in_pose_index (in_pose_index),
    .in_pose_value (in_pose_value),
    .q_count       (q_count),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  dpbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .pop_item  (q_out),
    .empty     (q_empty),
    .count     (q_count)
  );

  dpbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_item     (q_out),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_result (res)
  );

  assign out_world_x   = res.world_x;
  assign out_world_y   = res.world_y;
  assign out_world_z   = res.world_z;
  assign out_red_out   = res.red;
  assign out_green_out = res.green;
  assign out_blue_out  = res.blue;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= Q_CW'(Q_DEPTH)) else $error("item queue overflow");

  a_full_when_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count == Q_CW'(Q_DEPTH)) |-> in_full) else $error("input open with full queue");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("pop from empty queue");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty) else $error("results present after reset");

endmodule

/* rtl/core/dpbp_front.sv */
module dpbp_front
  import dpbp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic                   in_op,
  input  logic [11:0]            in_column,
  input  logic [11:0]            in_row,
  input  logic [15:0]            in_depth_raw,
  input  logic [7:0]             in_red_in,
  input  logic [7:0]             in_green_in,
  input  logic [7:0]             in_blue_in,
  input  logic [3:0]             in_pose_index,
  input  logic signed [31:0]     in_pose_value,
  input  logic [Q_CW-1:0]        q_count,
  output logic                   q_push,
  output item_t                  q_item
);

  logic                     f_v_r;
  logic                     f_op_r;
  logic [PROD_W-1:0]        f_prod_r;
  logic                     f_nz_r;
  logic signed [DIFF_W-1:0] f_du_r;
  logic signed [DIFF_W-1:0] f_dv_r;
  logic [7:0]               f_red_r;
  logic [7:0]               f_green_r;
  logic [7:0]               f_blue_r;
  logic [3:0]               f_idx_r;
  logic signed [31:0]       f_val_r;

  logic                     accept;
  logic [11:0]              u_m;
  logic [11:0]              v_m;
  logic [Z_W-1:0]           z;
  logic [CMP_W-1:0]         z_c;
  logic                     keep;

  assign in_full = ({1'b0, q_count} + (Q_CW + 1)'(f_v_r)) >= (Q_CW + 1)'(Q_DEPTH);
  assign accept  = in_push && !in_full;
  assign u_m     = in_column & COORD_MASK;
  assign v_m     = in_row & COORD_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_op_r    <= in_op;
      f_prod_r  <= PROD_W'(in_depth_raw) * PROD_W'(cfg.inv_depth_unit);
      f_nz_r    <= (in_depth_raw != 16'd0);
      f_du_r    <= $signed({1'b0, u_m, 8'b0}) - $signed({1'b0, cfg.center_x});
      f_dv_r    <= $signed({1'b0, v_m, 8'b0}) - $signed({1'b0, cfg.center_y});
      f_red_r   <= in_red_in;
      f_green_r <= in_green_in;
      f_blue_r  <= in_blue_in;
      f_idx_r   <= in_pose_index;
      f_val_r   <= in_pose_value;
    end
  end

  assign z   = f_prod_r[PROD_W-1:Z_SHIFT];
  assign z_c = CMP_W'(z);

  always_comb begin
    if (f_op_r) begin
      keep = (f_idx_r < 4'(POSE_WORDS));
    end else begin
      keep = f_nz_r && (cfg.inv_focal_x != 24'd0) && (cfg.inv_focal_y != 24'd0)
             && (z_c >= CMP_W'(cfg.min_depth)) && (z_c <= CMP_W'(cfg.max_depth));
    end
  end

  assign q_push            = f_v_r && keep;
  assign q_item.kind       = f_op_r ? ITEM_POSE : ITEM_PIXEL;
  assign q_item.z          = z;
  assign q_item.du         = f_du_r;
  assign q_item.dv         = f_dv_r;
  assign q_item.red        = f_red_r;
  assign q_item.green      = f_green_r;
  assign q_item.blue       = f_blue_r;
  assign q_item.pose_index = f_idx_r;
  assign q_item.pose_value = f_val_r;

endmodule

/* rtl/core/dpbp_queue.sv */
module dpbp_queue
  import dpbp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  item_t           push_item,
  input  logic            pop,
  output item_t           pop_item,
  output logic            empty,
  output logic [Q_CW-1:0] count
);

  item_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r;
  logic [Q_AW-1:0] rd_r;
  logic [Q_CW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      count_r <= count_r + Q_CW'(push) - Q_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

  assign pop_item = mem_r[rd_r];
  assign empty    = (count_r == '0);
  assign count    = count_r;

endmodule

/* rtl/core/dpbp_back.sv */
module dpbp_back
  import dpbp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    q_empty,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    out_empty,
  input  logic    out_pop,
  output result_t out_result
);

  logic signed [31:0] pose_r [POSE_ROWS][POSE_COLS];

  // stage 1: magnitude times focal reciprocal
  logic               s1_v_r;
  item_kind_t         s1_kind_r;
  logic [A_W-1:0]     s1_ax_r;
  logic [A_W-1:0]     s1_ay_r;
  logic               s1_nx_r;
  logic               s1_ny_r;
  logic [Z_W-1:0]     s1_z_r;
  logic [23:0]        s1_rgb_r;
  logic [3:0]         s1_idx_r;
  logic signed [31:0] s1_val_r;

  // stage 2: partial products with depth
  logic                    s2_v_r;
  item_kind_t              s2_kind_r;
  logic [AH_W+Z_W-1:0]     s2_hx_r;
  logic [32+Z_W-1:0]       s2_lx_r;
  logic [AH_W+Z_W-1:0]     s2_hy_r;
  logic [32+Z_W-1:0]       s2_ly_r;
  logic                    s2_nx_r;
  logic                    s2_ny_r;
  logic signed [31:0]      s2_cz_r;
  logic [23:0]             s2_rgb_r;
  logic [3:0]              s2_idx_r;
  logic signed [31:0]      s2_val_r;

  // stage 3: camera point
  logic               s3_v_r;
  item_kind_t         s3_kind_r;
  logic signed [31:0] s3_c_r [3];
  logic [23:0]        s3_rgb_r;
  logic [3:0]         s3_idx_r;
  logic signed [31:0] s3_val_r;

  // stage 4: pose products
  logic               s4_v_r;
  item_kind_t         s4_kind_r;
  logic signed [63:0] s4_p_r [POSE_ROWS][3];
  logic signed [31:0] s4_t_r [POSE_ROWS];
  logic [23:0]        s4_rgb_r;

  result_t            ob_r [OB_DEPTH];
  logic [OB_AW-1:0]   ob_wr_r;
  logic [OB_AW-1:0]   ob_rd_r;
  logic [OB_CW-1:0]   ob_count_r;

  logic [OB_CW:0]     pending;
  logic               ob_push;
  logic               ob_pop;
  logic [MAG_W-1:0]   mag_x;
  logic [MAG_W-1:0]   mag_y;
  logic [M_W-1:0]     m_x;
  logic [M_W-1:0]     m_y;
  logic [31:0]        cx;
  logic [31:0]        cy;
  logic signed [31:0] world [POSE_ROWS];
  result_t            res;

  localparam logic [M_W-1:0]   M_NEG_LIM = M_W'(64'h8000_0000);
  localparam logic [M_W-1:0]   M_POS_LIM = M_W'(64'h7FFF_FFFF);
  localparam logic [CMP_W-1:0] Z_LIM     = CMP_W'(64'h7FFF_FFFF);

  function automatic logic [31:0] cam_sat(input logic [M_W-1:0] m, input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (m > M_NEG_LIM) ? 32'h8000_0000 : 32'(-m);
    end else begin
      r = (m > M_POS_LIM) ? 32'h7FFF_FFFF : m[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] row_sum(input logic signed [63:0] p0,
                                                 input logic signed [63:0] p1,
                                                 input logic signed [63:0] p2,
                                                 input logic signed [31:0] t);
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-17:0] h;
    logic signed [31:0] r;
    s = SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2) + (SUM_W'(t) <<< FRAC_BITS);
    h = s[SUM_W-1:16];
    if (h[SUM_W-17:31] == '0 || h[SUM_W-17:31] == '1) begin
      r = h[31:0];
    end else begin
      r = h[SUM_W-17] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  assign pending = {1'b0, ob_count_r} + (OB_CW + 1)'(s1_v_r) + (OB_CW + 1)'(s2_v_r)
                   + (OB_CW + 1)'(s3_v_r) + (OB_CW + 1)'(s4_v_r);
  assign q_pop   = !q_empty && (pending < (OB_CW + 1)'(OB_DEPTH));

  assign mag_x = q_item.du[DIFF_W-1] ? MAG_W'(-q_item.du) : MAG_W'(q_item.du);
  assign mag_y = q_item.dv[DIFF_W-1] ? MAG_W'(-q_item.dv) : MAG_W'(q_item.dv);

  assign m_x = M_W'(s2_hx_r) + M_W'(s2_lx_r[32+Z_W-1:32]);
  assign m_y = M_W'(s2_hy_r) + M_W'(s2_ly_r[32+Z_W-1:32]);
  assign cx  = cam_sat(m_x, s2_nx_r);
  assign cy  = cam_sat(m_y, s2_ny_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      for (int r = 0; r < POSE_ROWS; r++) begin
        for (int c = 0; c < POSE_COLS; c++) begin
          pose_r[r][c] <= (r == c) ? ONE_POSE : 32'sd0;
        end
      end
    end else begin
      s1_v_r <= q_pop;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r && (s3_kind_r == ITEM_PIXEL);
      if (s3_v_r && s3_kind_r == ITEM_POSE) begin
        pose_r[s3_idx_r[3:2]][s3_idx_r[1:0]] <= s3_val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_kind_r <= q_item.kind;
    s1_ax_r   <= A_W'(mag_x) * A_W'(cfg.inv_focal_x);
    s1_ay_r   <= A_W'(mag_y) * A_W'(cfg.inv_focal_y);
    s1_nx_r   <= q_item.du[DIFF_W-1];
    s1_ny_r   <= q_item.dv[DIFF_W-1];
    s1_z_r    <= q_item.z;
    s1_rgb_r  <= {q_item.red, q_item.green, q_item.blue};
    s1_idx_r  <= q_item.pose_index;
    s1_val_r  <= q_item.pose_value;

    s2_kind_r <= s1_kind_r;
    s2_hx_r   <= (AH_W + Z_W)'(s1_ax_r[A_W-1:32]) * (AH_W + Z_W)'(s1_z_r);
    s2_lx_r   <= (32 + Z_W)'(s1_ax_r[31:0]) * (32 + Z_W)'(s1_z_r);
    s2_hy_r   <= (AH_W + Z_W)'(s1_ay_r[A_W-1:32]) * (AH_W + Z_W)'(s1_z_r);
    s2_ly_r   <= (32 + Z_W)'(s1_ay_r[31:0]) * (32 + Z_W)'(s1_z_r);
    s2_nx_r   <= s1_nx_r;
    s2_ny_r   <= s1_ny_r;
    s2_cz_r   <= (CMP_W'(s1_z_r) > Z_LIM) ? 32'sh7FFF_FFFF : $signed(s1_z_r[31:0]);
    s2_rgb_r  <= s1_rgb_r;
    s2_idx_r  <= s1_idx_r;
    s2_val_r  <= s1_val_r;

    s3_kind_r <= s2_kind_r;
    s3_c_r[0] <= $signed(cx);
    s3_c_r[1] <= $signed(cy);
    s3_c_r[2] <= s2_cz_r;
    s3_rgb_r  <= s2_rgb_r;
    s3_idx_r  <= s2_idx_r;
    s3_val_r  <= s2_val_r;

    s4_kind_r <= s3_kind_r;
    for (int r = 0; r < POSE_ROWS; r++) begin
      for (int c = 0; c < 3; c++) begin
        s4_p_r[r][c] <= pose_r[r][c] * s3_c_r[c];
      end
      s4_t_r[r] <= pose_r[r][3];
    end
    s4_rgb_r <= s3_rgb_r;
  end

  always_comb begin
    for (int r = 0; r < POSE_ROWS; r++) begin
      world[r] = row_sum(s4_p_r[r][0], s4_p_r[r][1], s4_p_r[r][2], s4_t_r[r]);
    end
  end

  assign res.world_x = world[0];
  assign res.world_y = world[1];
  assign res.world_z = world[2];
  assign res.red     = s4_rgb_r[23:16];
  assign res.green   = s4_rgb_r[15:8];
  assign res.blue    = s4_rgb_r[7:0];

  assign ob_push = s4_v_r && (s4_kind_r == ITEM_PIXEL);
  assign ob_pop  = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_r    <= '0;
      ob_rd_r    <= '0;
      ob_count_r <= '0;
    end else begin
      if (ob_push) ob_wr_r <= ob_wr_r + 1'b1;
      if (ob_pop)  ob_rd_r <= ob_rd_r + 1'b1;
      ob_count_r <= ob_count_r + OB_CW'(ob_push) - OB_CW'(ob_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (ob_push) ob_r[ob_wr_r] <= res;
  end

  assign out_empty  = (ob_count_r == '0);
  assign out_result = ob_r[ob_rd_r];

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
  import dpbp_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic               in_op = 1'b0;
  logic [11:0]        in_column = '0;
  logic [11:0]        in_row = '0;
  logic [15:0]        in_depth_raw = '0;
  logic [7:0]         in_red_in = '0;
  logic [7:0]         in_green_in = '0;
  logic [7:0]         in_blue_in = '0;
  logic [3:0]         in_pose_index = '0;
  logic signed [31:0] in_pose_value = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [31:0] out_world_x;
  logic signed [31:0] out_world_y;
  logic signed [31:0] out_world_z;
  logic [7:0]         out_red_out;
  logic [7:0]         out_green_out;
  logic [7:0]         out_blue_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  depth_pixel_backprojection_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [23:0] m_ifx, m_ify, m_idu;
  logic [19:0] m_cx, m_cy;
  logic [31:0] m_dmin, m_dmax;
  logic signed [31:0] m_pose [POSE_WORDS];

  result_t points_due [$];
  int      errors = 0;
  bit      pop_idle = 1'b0;

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint cam_axis(input longint d, input logic [23:0] inv,
                                      input longint unsigned z);
    longint unsigned mag, a, m;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    a = mag * inv;
    m = (a >> 32) * z + (((a & 64'hFFFF_FFFF) * z) >> 32);
    if (d < 0) begin
      if (m > 64'd2147483648) m = 64'd2147483648;
      return -longint'(m);
    end
    if (m > 64'd2147483647) m = 64'd2147483647;
    return longint'(m);
  endfunction

  function automatic logic signed [31:0] world_axis(input int r, input longint c [4]);
    logic signed [95:0] acc;
    acc = '0;
    for (int j = 0; j < 4; j++) acc += 96'(m_pose[r*4+j]) * 96'(c[j]);
    acc = acc >>> 16;
    if (acc > 96'sd2147483647) return 32'sh7FFF_FFFF;
    if (acc < -96'sd2147483648) return 32'sh8000_0000;
    return acc[31:0];
  endfunction

  task automatic predict_point(input logic op, input logic [11:0] u, input logic [11:0] v,
                               input logic [15:0] draw, input logic [7:0] r,
                               input logic [7:0] g, input logic [7:0] b,
                               input logic [3:0] pidx, input logic signed [31:0] pval);
    longint unsigned z;
    longint c [4];
    result_t p;
    if (op == ITEM_POSE) begin
      if (pidx < POSE_WORDS) m_pose[pidx] = pval;
      return;
    end
    if (draw == 0 || m_ifx == 0 || m_ify == 0) return;
    z = (longint'(draw) * m_idu) >> (24 - FRAC_BITS);
    if (z < m_dmin || z > m_dmax) return;
    c[0] = cam_axis(longint'(u & COORD_MASK) * 256 - m_cx, m_ifx, z);
    c[1] = cam_axis(longint'(v & COORD_MASK) * 256 - m_cy, m_ify, z);
    c[2] = sat32(longint'(z));
    c[3] = 64'd1 << FRAC_BITS;
    p.world_x = world_axis(0, c);
    p.world_y = world_axis(1, c);
    p.world_z = world_axis(2, c);
    p.red = r;
    p.green = g;
    p.blue = b;
    points_due = {points_due, p};
  endtask

  task automatic send_item(input logic op, input logic [11:0] u, input logic [11:0] v,
                           input logic [15:0] draw, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b,
                           input logic [3:0] pidx, input logic signed [31:0] pval);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 1)) gap = 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_op <= op;
    in_column <= u;
    in_row <= v;
    in_depth_raw <= draw;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    in_pose_index <= pidx;
    in_pose_value <= pval;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_point(op, u, v, draw, r, g, b, pidx, pval);
  endtask

  task automatic send_pixel(input logic [11:0] u, input logic [11:0] v,
                            input logic [15:0] draw);
    send_item(ITEM_PIXEL, u, v, draw, 8'($urandom), 8'($urandom), 8'($urandom),
              4'($urandom), 32'($urandom));
  endtask

  task automatic send_pose(input logic [3:0] pidx, input logic signed [31:0] pval);
    send_item(ITEM_POSE, 12'($urandom), 12'($urandom), 16'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), pidx, pval);
  endtask

  task automatic drain;
    in_push <= 1'b0;
    while (points_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_INV_FOCAL_X:    m_ifx = val[23:0];
      CFG_INV_FOCAL_Y:    m_ify = val[23:0];
      CFG_CENTER_X:       m_cx = val[19:0];
      CFG_CENTER_Y:       m_cy = val[19:0];
      CFG_INV_DEPTH_UNIT: m_idu = val[23:0];
      CFG_MIN_DEPTH:      m_dmin = val;
      CFG_MAX_DEPTH:      m_dmax = val;
      default: ;
    endcase
  endtask

  task automatic set_optics(input logic [23:0] ifx, input logic [23:0] ify,
                            input logic [19:0] cx, input logic [19:0] cy,
                            input logic [23:0] idu, input logic [31:0] dmin,
                            input logic [31:0] dmax);
    drain();
    write_reg(CFG_INV_FOCAL_X, ifx);
    write_reg(CFG_INV_FOCAL_Y, ify);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_INV_DEPTH_UNIT, idu);
    write_reg(CFG_MIN_DEPTH, dmin);
    write_reg(CFG_MAX_DEPTH, dmax);
    cfg_valid <= 1'b0;
  endtask

  // rotation-ish entries between minus one and one, occasionally wild
  function automatic logic signed [31:0] rand_pose_word;
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'($urandom);
      default: return 32'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  task automatic test_directed;
    send_pixel(12'd320, 12'd240, 16'd1000);
    send_pixel(12'd0, 12'd0, 16'd1000);
    send_pixel(12'hFFF, 12'hFFF, 16'd1000);
    send_pixel(12'd100, 12'd50, 16'd0);
    send_pixel(12'd100, 12'd50, 16'd1);
    send_pixel(12'd100, 12'd50, 16'hFFFF);
    send_pixel(12'd100, 12'd50, 16'd1172);
    send_pose(4'd3, 32'sh0001_8000);
    send_pose(4'd7, 32'sh8000_0000);
    send_pose(4'd11, 32'sh7FFF_FFFF);
    send_pose(4'd12, 32'sh1234_5678);
    send_pose(4'd15, 32'shFFFF_FFFF);
    send_item(ITEM_PIXEL, 12'd5, 12'd9, 16'd3000, 8'hFF, 8'h00, 8'hAA, 4'hF, 32'hFFFF_FFFF);
    send_pose(4'd0, 32'sh7FFF_FFFF);
    send_pose(4'd1, 32'sh7FFF_FFFF);
    send_pixel(12'hFFF, 12'd0, 16'd9000);
    send_pixel(12'd0, 12'hFFF, 16'd9000);
    // large coordinates and extreme depth
    set_optics(24'hFF_FFFF, 24'hFF_FFFF, 20'd0, 20'hF_FFFF, 24'hFF_FFFF, 32'd0,
               32'hFFFF_FFFF);
    send_pixel(12'hFFF, 12'd0, 16'hFFFF);
    send_pixel(12'd0, 12'd0, 16'hFFFF);
    send_pixel(12'hFFF, 12'hFFF, 16'd1);
    // zero focal and inverted window
    set_optics(24'd0, 24'd32263, 20'd81920, 20'd61440, 24'd16777, 32'd0, 32'hFFFF_FFFF);
    send_pixel(12'd10, 12'd10, 16'd1000);
    set_optics(24'd32263, 24'd0, 20'd81920, 20'd61440, 24'd16777, 32'd0, 32'hFFFF_FFFF);
    send_pixel(12'd10, 12'd10, 16'd1000);
    set_optics(24'd32263, 24'd32263, 20'd81920, 20'd61440, 24'd16777, 32'd70000,
               32'd60000);
    send_pixel(12'd10, 12'd10, 16'd4000);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_pose(4'($urandom_range(0, 15)), rand_pose_word());
      end else begin
        send_pixel(12'($urandom), 12'($urandom),
                   ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2))
                                                : 16'($urandom));
      end
      if (i == n / 2) drain();
    end
  endtask

  task automatic test_settings;
    set_optics(24'd32263, 24'd32263, 20'd81920, 20'd61440, 24'd16777, 32'd0,
               32'hFFFF_FFFF);
    for (int k = 0; k < POSE_WORDS; k++) send_pose(4'(k), rand_pose_word());
    test_random(400);
    set_optics(24'($urandom), 24'($urandom), 20'($urandom), 20'($urandom),
               24'($urandom), 32'($urandom_range(0, 200000)), 32'hFFFF_FFFF);
    test_random(300);
    set_optics(24'd1, 24'd1, 20'hF_FFFF, 20'd0, 24'd1, 32'd0, 32'd100);
    test_random(150);
    set_optics(24'd32263, 24'd40000, 20'd81920, 20'd61440, 24'd16777, 32'd19661,
               32'd655360);
    test_random(500);
  endtask

  initial begin
    for (int k = 0; k < POSE_WORDS; k++) m_pose[k] = 32'sd0;
    m_pose[0] = ONE_POSE;
    m_pose[5] = ONE_POSE;
    m_pose[10] = ONE_POSE;
    m_ifx = 24'd32263; m_ify = 24'd32263;
    m_cx = 20'd81920; m_cy = 20'd61440;
    m_idu = 24'd16777; m_dmin = 32'd19661; m_dmax = 32'd655360;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_settings();
    drain();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (points_due.size() == 0) begin
          $display("%0t unexpected item x=%0d y=%0d z=%0d", $time, out_world_x,
                   out_world_y, out_world_z);
          errors++;
        end else begin
          result_t e;
          e = points_due.pop_front();
          if (e.world_x !== out_world_x) begin
            $display("%0t world_x exp %0d got %0d", $time, e.world_x, out_world_x);
            errors++;
          end
          if (e.world_y !== out_world_y) begin
            $display("%0t world_y exp %0d got %0d", $time, e.world_y, out_world_y);
            errors++;
          end
          if (e.world_z !== out_world_z) begin
            $display("%0t world_z exp %0d got %0d", $time, e.world_z, out_world_z);
            errors++;
          end
          if (e.red !== out_red_out) begin
            $display("%0t red exp %0d got %0d", $time, e.red, out_red_out);
            errors++;
          end
          if (e.green !== out_green_out) begin
            $display("%0t green exp %0d got %0d", $time, e.green, out_green_out);
            errors++;
          end
          if (e.blue !== out_blue_out) begin
            $display("%0t blue exp %0d got %0d", $time, e.blue, out_blue_out);
            errors++;
          end
        end
      end
    end
  end

  // receiver stalls: per item a random wait, with long no-stall stretches
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (out_pop && !out_empty) begin
      stall_left = pop_idle ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 2) == 0) stall_left = 0;
      out_pop <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_pop <= (stall_left == 0);
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 499) == 0) pop_idle <= ~pop_idle;
  end

  initial begin
    #5ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/dpbp_pkg.sv
rtl/core/dpbp_front.sv
rtl/core/dpbp_queue.sv
rtl/core/dpbp_back.sv
rtl/core/depth_pixel_backprojection_unit.sv
test/tb.sv
